// File: design/ctb_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared types, field widths and opcode/state encodings.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int OP_W        = 3;
    localparam int SLOT_W      = 3;
    localparam int TICKS_W     = 32;
    localparam int HOOK_W      = 8;
    localparam int DONE_W      = 8;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_ARM    = 3'd1,
        OP_REARM  = 3'd2,
        OP_ALLOC  = 3'd3,
        OP_FREE   = 3'd4,
        OP_STATUS = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EVENT,
        ST_STATUS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic walk_step;
        logic idx_clr;
        logic idx_inc;
        logic emit_event;
        logic emit_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  in_op;
        op_t  cur_op;
        logic tick_on;
        logic idx_last;
        logic ev_bit;
        logic out_free;
    } stat_t;

endpackage

// File: design/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// Countdown timer bank controller
// Sequences load, slot walk, event emission and the closing status word.
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ctb_pkg::stat_t stat,
    output ctb_pkg::cmd_t  cmd
);
    import ctb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if ((stat.in_op == OP_TICK && stat.tick_on) || stat.in_op == OP_ALLOC) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_WALK: begin
                if (stat.idx_last) begin
                    state_next = (stat.cur_op == OP_TICK) ? ST_EVENT : ST_STATUS;
                end
            end
            ST_EVENT: begin
                if (stat.idx_last && (!stat.ev_bit || stat.out_free)) begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load    = s_tvalid;
                cmd.idx_clr = s_tvalid;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                cmd.idx_clr   = stat.idx_last;
                cmd.idx_inc   = !stat.idx_last;
            end
            ST_EVENT: begin
                // A pending event holds the scan until the output register frees up.
                if (!stat.ev_bit || stat.out_free) begin
                    cmd.emit_event = stat.ev_bit;
                    cmd.idx_inc    = !stat.idx_last;
                end
            end
            ST_STATUS: begin
                cmd.emit_status = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: design/ctb_datapath.sv
// ----------------------------------------------------------------------------
// Countdown timer bank datapath
// Slot counters, reload values, flags, tick counter and the output register.
// ----------------------------------------------------------------------------
module ctb_datapath #(
    parameter int NUM_SLOTS   = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int IDX_W       = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ctb_pkg::IN_TDATA_W-1:0]      in_data,
    input  logic                                cfg_wr_en,
    input  logic [ctb_pkg::HOOK_W-1:0]          cfg_wr_data,
    input  ctb_pkg::cmd_t                       cmd,
    output ctb_pkg::stat_t                      stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ctb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import ctb_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    logic [COUNT_WIDTH-1:0] remaining_reg [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] remaining_next[NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] reload_reg    [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] reload_next   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   done_reg, done_next;
    logic [NUM_SLOTS-1:0]   ev_reg, ev_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    op_t                    op_reg, op_next;
    logic                   any_reg, any_next;
    logic                   found_reg, found_next;
    logic [SLOT_W-1:0]      alloc_slot_reg, alloc_slot_next;
    logic                   tick_en_reg, tick_en_next;
    logic [TOTAL_W-1:0]     tick_cnt_reg, tick_cnt_next;
    logic [HOOK_W-1:0]      hook_reg;

    logic                   m_valid_reg;
    logic                   m_kind_reg;
    logic                   m_last_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic                   m_ok_reg;
    logic [DONE_W-1:0]      m_done_reg;
    logic                   m_en_reg;
    logic [TOTAL_W-1:0]     m_total_reg;

    op_t                    in_op;
    logic [SLOT_W-1:0]      in_slot;
    logic [TICKS_W-1:0]     in_ticks;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_ok;
    logic [IDX_W-1:0]       rd_idx;
    logic [COUNT_WIDTH-1:0] rem_rd, rel_rd, rem_dec, arm_val;
    logic [NUM_SLOTS-1:0]   hook_vec;
    logic [DONE_W-1:0]      done_view;
    logic                   out_free;

    assign in_op    = op_t'(in_data[OP_W-1:0]);
    assign in_slot  = in_data[OP_W +: SLOT_W];
    assign in_ticks = in_data[OP_W+SLOT_W +: TICKS_W];
    assign slot_idx = IDX_W'(in_slot);
    assign slot_ok  = (32'(in_slot) < NUM_SLOTS);
    assign arm_val  = COUNT_WIDTH'(in_ticks) + COUNT_WIDTH'(1);

    // Only the first eight slots can be hooked or show their done flag.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_hook
        if (g < HOOK_W) begin : g_on
            assign hook_vec[g] = hook_reg[g];
        end else begin : g_off
            assign hook_vec[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < DONE_W; g++) begin : g_done
        if (g < NUM_SLOTS) begin : g_on
            assign done_view[g] = done_reg[g];
        end else begin : g_off
            assign done_view[g] = 1'b0;
        end
    end

    assign rd_idx   = cmd.walk_step ? idx_reg : slot_idx;
    assign rem_rd   = remaining_reg[rd_idx];
    assign rel_rd   = reload_reg[rd_idx];
    assign rem_dec  = rem_rd - COUNT_WIDTH'(1);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        stat.in_op    = in_op;
        stat.cur_op   = op_reg;
        stat.tick_on  = tick_en_reg;
        stat.idx_last = (idx_reg == IDX_LAST);
        stat.ev_bit   = ev_reg[idx_reg];
        stat.out_free = out_free;
    end

    always_comb begin
        remaining_next  = remaining_reg;
        reload_next     = reload_reg;
        done_next       = done_reg;
        ev_next         = ev_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        any_next        = any_reg;
        found_next      = found_reg;
        alloc_slot_next = alloc_slot_reg;
        tick_en_next    = tick_en_reg;
        tick_cnt_next   = tick_cnt_reg;

        if (cmd.load) begin
            op_next         = in_op;
            ev_next         = '0;
            any_next        = 1'b0;
            found_next      = 1'b0;
            alloc_slot_next = '0;
            case (in_op)
                OP_TICK: begin
                    if (tick_en_reg) begin
                        tick_cnt_next = tick_cnt_reg + TOTAL_W'(1);
                    end
                end
                OP_ARM: begin
                    if (slot_ok) begin
                        remaining_next[slot_idx] = arm_val;
                        reload_next[slot_idx]    = arm_val;
                        done_next[slot_idx]      = 1'b0;
                        tick_en_next             = 1'b1;
                    end
                end
                OP_REARM: begin
                    if (slot_ok) begin
                        remaining_next[slot_idx] = rel_rd;
                        tick_en_next             = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (slot_ok) begin
                        reload_next[slot_idx] = '0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.walk_step) begin
            if (op_reg == OP_TICK) begin
                if (rem_rd != '0) begin
                    remaining_next[idx_reg] = rem_dec;
                    if (rem_dec == '0) begin
                        if (hook_vec[idx_reg]) begin
                            ev_next[idx_reg] = 1'b1;
                        end else begin
                            done_next[idx_reg] = 1'b1;
                        end
                    end
                end
                any_next = any_reg || (rem_rd != '0 && rem_dec != '0);
                // The enable drops once the walk has seen every count at zero.
                if (idx_reg == IDX_LAST) begin
                    tick_en_next = any_next;
                end
            end else if (rel_rd == '0 && !found_reg) begin
                found_next      = 1'b1;
                alloc_slot_next = SLOT_W'(idx_reg);
            end
        end

        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                remaining_reg[i] <= '0;
                reload_reg[i]    <= '0;
            end
            done_reg     <= '0;
            ev_reg       <= '0;
            idx_reg      <= '0;
            op_reg       <= OP_STATUS;
            any_reg      <= 1'b0;
            found_reg    <= 1'b0;
            tick_en_reg  <= 1'b0;
            tick_cnt_reg <= '0;
            hook_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            done_reg      <= done_next;
            ev_reg        <= ev_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            any_reg       <= any_next;
            found_reg     <= found_next;
            tick_en_reg   <= tick_en_next;
            tick_cnt_reg  <= tick_cnt_next;
            if (cfg_wr_en) begin
                hook_reg <= cfg_wr_data;
            end
            if (cmd.emit_event || cmd.emit_status) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        alloc_slot_reg <= alloc_slot_next;
        if (cmd.emit_event || cmd.emit_status) begin
            m_kind_reg  <= cmd.emit_event;
            m_last_reg  <= cmd.emit_status;
            m_slot_reg  <= cmd.emit_event ? SLOT_W'(idx_reg) : alloc_slot_reg;
            m_ok_reg    <= cmd.emit_status && found_reg;
            m_done_reg  <= done_view;
            m_en_reg    <= tick_en_reg;
            m_total_reg <= tick_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_total_reg, m_en_reg, m_done_reg, m_ok_reg, m_slot_reg};

endmodule

// File: design/countdown_timer_bank_core.sv
// Arm, rearm, free, status and disabled tick words go from acceptance straight to their
// status word. An enabled tick walks the slots twice (count down, then event scan) before
// its status word; allocate walks once. One word is in flight at a time, and output
// stalls hold the sequence. Reset (aresetn low, synchronous) clears all slot state, the
// tick counter, enable and hook mask.
// ----------------------------------------------------------------------------
// Countdown timer bank core
// Bank of countdown slots with tick, arm, rearm, allocate, free and status words.
// ----------------------------------------------------------------------------
module countdown_timer_bank_core #(
    parameter int NUM_SLOTS   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[2:0], slot[5:3], ticks[37:6], zero fill [39:38]
    input  logic [ctb_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot_out[2:0], alloc_ok[3], done_flags[11:4], tick_enabled[12],
    // tick_total[44:13], zero fill [47:45]
    output logic [ctb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [ctb_pkg::HOOK_W-1:0]      cfg_wr_data
);
    import ctb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    cmd_t  cmd;
    stat_t stat;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctb_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Only one word is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // Expiry events never close a word and never report an allocation.
    a_event_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (!m_tlast && !m_tdata[3]))
        else $error("expiry event carries last or alloc_ok");

    // The controller never issues an event and a status word together.
    a_single_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_event && cmd.emit_status))
        else $error("event and status emitted in the same cycle");

endmodule
